### rtl/bcss_pkg.sv
// ----------------------------------------------------------------------------
// bcss_pkg
// Shared widths, register indexes, phase codes and bundles for the breath
// cycle stepper sequencer.
// ----------------------------------------------------------------------------
package bcss_pkg;

  localparam int STEP_COUNT_WIDTH = 10;
  localparam int TICK_WIDTH       = 16;
  localparam int CFG_DATA_WIDTH   = (STEP_COUNT_WIDTH > TICK_WIDTH) ?
                                    STEP_COUNT_WIDTH : TICK_WIDTH;
  localparam int CFG_INDEX_WIDTH  = 3;

  // register reset values
  localparam logic [STEP_COUNT_WIDTH-1:0] TRAVEL_STEPS_RST   = STEP_COUNT_WIDTH'(800);
  localparam logic [TICK_WIDTH-1:0]       RISE_TICKS_RST     = TICK_WIDTH'(17);
  localparam logic [TICK_WIDTH-1:0]       INSP_PAUSE_RST     = TICK_WIDTH'(11979);
  localparam logic [TICK_WIDTH-1:0]       LOWER_TICKS_RST    = TICK_WIDTH'(13);
  localparam logic [TICK_WIDTH-1:0]       EXP_PAUSE_RST      = TICK_WIDTH'(41145);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_TRAVEL_STEPS     = 3'd0,
    REG_RISE_STEP_TICKS  = 3'd1,
    REG_INSP_PAUSE_TICKS = 3'd2,
    REG_LOWER_STEP_TICKS = 3'd3,
    REG_EXP_PAUSE_TICKS  = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_RISE  = 2'd0,
    PH_INSP  = 2'd1,
    PH_LOWER = 2'd2,
    PH_EXP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [STEP_COUNT_WIDTH-1:0] travel_steps;
    logic [TICK_WIDTH-1:0]       rise_step_ticks;
    logic [TICK_WIDTH-1:0]       insp_pause_ticks;
    logic [TICK_WIDTH-1:0]       lower_step_ticks;
    logic [TICK_WIDTH-1:0]       exp_pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic   step_pulse;
    logic   direction;
    logic   drive_enable;
    phase_t phase;
    logic   breath_done;
  } result_t;

endpackage

### rtl/bcss_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcss_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bcss_cfg_regs
  import bcss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_TRAVEL_STEPS:     cfg_nxt.travel_steps     = cfg_wdata[STEP_COUNT_WIDTH-1:0];
        REG_RISE_STEP_TICKS:  cfg_nxt.rise_step_ticks  = cfg_wdata[TICK_WIDTH-1:0];
        REG_INSP_PAUSE_TICKS: cfg_nxt.insp_pause_ticks = cfg_wdata[TICK_WIDTH-1:0];
        REG_LOWER_STEP_TICKS: cfg_nxt.lower_step_ticks = cfg_wdata[TICK_WIDTH-1:0];
        REG_EXP_PAUSE_TICKS:  cfg_nxt.exp_pause_ticks  = cfg_wdata[TICK_WIDTH-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.travel_steps     <= TRAVEL_STEPS_RST;
      cfg_r.rise_step_ticks  <= RISE_TICKS_RST;
      cfg_r.insp_pause_ticks <= INSP_PAUSE_RST;
      cfg_r.lower_step_ticks <= LOWER_TICKS_RST;
      cfg_r.exp_pause_ticks  <= EXP_PAUSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bcss_phase_core.sv
// ----------------------------------------------------------------------------
// bcss_phase_core
// Breath phase state machine with step and interval counters.
// ----------------------------------------------------------------------------
module bcss_phase_core
  import bcss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_load,
  input  logic    tick,
  output result_t result
);

  phase_t                      phase_r, phase_nxt;
  logic [STEP_COUNT_WIDTH-1:0] steps_left_r, steps_left_nxt;
  logic [TICK_WIDTH-1:0]       tick_cnt_r, tick_cnt_nxt;

  logic [TICK_WIDTH-1:0]       limit;
  logic [TICK_WIDTH:0]         cnt_inc;
  logic                        intv_end;
  logic [STEP_COUNT_WIDTH-1:0] steps_dec;
  logic                        pulse;
  logic                        done;

  // interval limit for the current phase; zero behaves as one
  always_comb begin
    case (phase_r)
      PH_RISE:  limit = cfg.rise_step_ticks;
      PH_INSP:  limit = cfg.insp_pause_ticks;
      PH_LOWER: limit = cfg.lower_step_ticks;
      PH_EXP:   limit = cfg.exp_pause_ticks;
      default:  limit = cfg.exp_pause_ticks;
    endcase
    if (limit == '0) begin
      limit = TICK_WIDTH'(1);
    end
  end

  assign cnt_inc   = {1'b0, tick_cnt_r} + (TICK_WIDTH+1)'(1);
  assign intv_end  = (cnt_inc >= {1'b0, limit});
  assign steps_dec = steps_left_r - STEP_COUNT_WIDTH'(1);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    steps_left_nxt = steps_left_r;
    tick_cnt_nxt   = tick_cnt_r;
    pulse          = 1'b0;
    done           = 1'b0;
    if (item_load && tick) begin
      case (phase_r)
        PH_RISE, PH_LOWER: begin
          if (steps_left_r == '0) begin
            tick_cnt_nxt = '0;
            phase_nxt    = (phase_r == PH_RISE) ? PH_INSP : PH_EXP;
          end else if (intv_end) begin
            tick_cnt_nxt   = '0;
            pulse          = 1'b1;
            steps_left_nxt = steps_dec;
            if (steps_dec == '0) begin
              phase_nxt = (phase_r == PH_RISE) ? PH_INSP : PH_EXP;
            end
          end else begin
            tick_cnt_nxt = cnt_inc[TICK_WIDTH-1:0];
          end
        end
        PH_INSP: begin
          if (intv_end) begin
            tick_cnt_nxt   = '0;
            steps_left_nxt = cfg.travel_steps;
            phase_nxt      = (cfg.travel_steps == '0) ? PH_EXP : PH_LOWER;
          end else begin
            tick_cnt_nxt = cnt_inc[TICK_WIDTH-1:0];
          end
        end
        default: begin
          if (intv_end) begin
            done           = 1'b1;
            tick_cnt_nxt   = '0;
            steps_left_nxt = cfg.travel_steps;
            phase_nxt      = (cfg.travel_steps == '0) ? PH_INSP : PH_RISE;
          end else begin
            tick_cnt_nxt = cnt_inc[TICK_WIDTH-1:0];
          end
        end
      endcase
    end
  end

  // outputs reflect the phase the tick was spent in
  always_comb begin
    result.step_pulse   = pulse;
    result.direction    = (phase_r == PH_LOWER);
    result.drive_enable = (phase_r != PH_EXP);
    result.phase        = phase_r;
    result.breath_done  = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RISE;
      steps_left_r <= TRAVEL_STEPS_RST;
      tick_cnt_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      steps_left_r <= steps_left_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
    end
  end

endmodule

### rtl/bcss_out_stage.sv
// ----------------------------------------------------------------------------
// bcss_out_stage
// Result register; refills in the same cycle it is drained.
// ----------------------------------------------------------------------------
module bcss_out_stage
  import bcss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result_in,
  output logic    full_hold,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result_out
);

  logic    out_valid_r, out_valid_nxt;
  result_t result_r, result_nxt;

  assign full_hold = out_valid_r && out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    result_nxt    = result_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      result_nxt    = result_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign result_out = result_r;

endmodule

### rtl/breath_cycle_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// breath_cycle_stepper_sequencer
// A result is valid in the cycle after its tick item is accepted.
// Throughput: one item per cycle while in_stall is low; the phase counters update as each item is taken.
// in_stall is high only while the result register is full and stalled.
// Reset (rst_n low, synchronous): rising phase, steps_left = 800,
// counter zero, registers at their reset values, result register empty.
// ----------------------------------------------------------------------------
module breath_cycle_stepper_sequencer
  import bcss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // tick item channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_tick,
  // result item channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_step_pulse,
  output logic                       out_direction,
  output logic                       out_drive_enable,
  output logic [1:0]                 out_phase,
  output logic                       out_breath_done,
  // configuration writes
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  cfg_t    cfg;
  result_t core_result;
  result_t out_result;
  logic    item_load;
  logic    full_hold;

  // Timing values arrive as precomputed tick counts.
  bcss_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // An item is taken whenever the result register is empty or draining.
  assign in_stall  = full_hold;
  assign item_load = in_valid && !full_hold;

  // Phase sequencer: every accepted item yields exactly one result;
  // a zero tick leaves the state alone and reports the current phase.
  bcss_phase_core u_phase_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_load (item_load),
    .tick      (in_tick),
    .result    (core_result)
  );

  bcss_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (item_load),
    .result_in  (core_result),
    .full_hold  (full_hold),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (out_result)
  );

  assign out_step_pulse   = out_result.step_pulse;
  assign out_direction    = out_result.direction;
  assign out_drive_enable = out_result.drive_enable;
  assign out_phase        = out_result.phase;
  assign out_breath_done  = out_result.breath_done;

  // breath_done only ends the expiration pause
  a_done_in_exp : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_breath_done) |-> (out_phase == PH_EXP))
    else $error("breath_done outside expiration pause");

  // steps are only issued in the rising or lowering phase
  a_pulse_in_step : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_pulse) |-> (out_phase == PH_RISE || out_phase == PH_LOWER))
    else $error("step pulse outside a step phase");

  // every accepted item leaves a result waiting next cycle
  a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  // direction and enable follow the reported phase
  a_drive_follows_phase : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_direction == (out_phase == PH_LOWER)) &&
                   (out_drive_enable == (out_phase != PH_EXP))))
    else $error("direction or enable inconsistent with phase");

endmodule

### bench/tb_breath_cycle_stepper_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_breath_cycle_stepper_sequencer
// Self-checking bench for the breath cycle stepper sequencer. The bench feeds
// tick items through the valid/stall channel and keeps its own model of the
// four-phase breath cycle. Every result item is compared field by field with
// the oldest prediction. Registers are reprogrammed only while nothing is in
// flight. The sender idles in bursts, the receiver stalls in patterns, and
// one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_breath_cycle_stepper_sequencer;
  import bcss_pkg::*;

  // --------------------------------------------------------------------------
  // Breath cycle model plus the queue of predicted result items
  // --------------------------------------------------------------------------
  class breath_scoreboard;
    logic [STEP_COUNT_WIDTH-1:0] travel;
    logic [TICK_WIDTH-1:0]       rise_ticks;
    logic [TICK_WIDTH-1:0]       insp_ticks;
    logic [TICK_WIDTH-1:0]       lower_ticks;
    logic [TICK_WIDTH-1:0]       exp_ticks;
    phase_t                      ph;
    logic [STEP_COUNT_WIDTH-1:0] steps_left;
    logic [TICK_WIDTH-1:0]       tick_cnt;
    result_t                     pending_results[$];
    int                          errors;
    int                          results_seen;

    function new();
      travel       = TRAVEL_STEPS_RST;
      rise_ticks   = RISE_TICKS_RST;
      insp_ticks   = INSP_PAUSE_RST;
      lower_ticks  = LOWER_TICKS_RST;
      exp_ticks    = EXP_PAUSE_RST;
      ph           = PH_RISE;
      steps_left   = TRAVEL_STEPS_RST;
      tick_cnt     = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                          logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_TRAVEL_STEPS:     travel      = data[STEP_COUNT_WIDTH-1:0];
        REG_RISE_STEP_TICKS:  rise_ticks  = data[TICK_WIDTH-1:0];
        REG_INSP_PAUSE_TICKS: insp_ticks  = data[TICK_WIDTH-1:0];
        REG_LOWER_STEP_TICKS: lower_ticks = data[TICK_WIDTH-1:0];
        REG_EXP_PAUSE_TICKS:  exp_ticks   = data[TICK_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // true when the running interval finishes on this tick; zero acts as one
    function bit interval_over(logic [TICK_WIDTH-1:0] limit);
      logic [TICK_WIDTH:0] lim;
      logic [TICK_WIDTH:0] nxt;
      lim = (limit == '0) ? (TICK_WIDTH+1)'(1) : {1'b0, limit};
      nxt = {1'b0, tick_cnt} + 1'b1;
      if (nxt >= lim) begin
        tick_cnt = '0;
        return 1'b1;
      end
      tick_cnt = nxt[TICK_WIDTH-1:0];
      return 1'b0;
    endfunction

    // step phase entry; zero travel falls straight through to the pause
    function void start_stroke(phase_t stroke, phase_t pause);
      tick_cnt   = '0;
      steps_left = travel;
      ph         = (travel == '0) ? pause : stroke;
    endfunction

    function void note_tick(logic tick);
      result_t r;
      phase_t  spent;
      phase_t  after;
      spent          = ph;
      after          = (spent == PH_RISE) ? PH_INSP : PH_EXP;
      r              = '0;
      r.phase        = spent;
      r.direction    = (spent == PH_LOWER);
      r.drive_enable = (spent != PH_EXP);
      if (tick) begin
        case (spent)
          PH_RISE, PH_LOWER: begin
            if (steps_left == '0) begin
              tick_cnt = '0;
              ph       = after;
            end else if (interval_over(spent == PH_RISE ? rise_ticks : lower_ticks)) begin
              r.step_pulse = 1'b1;
              steps_left   = steps_left - 1'b1;
              if (steps_left == '0) ph = after;
            end
          end
          PH_INSP: begin
            if (interval_over(insp_ticks)) start_stroke(PH_LOWER, PH_EXP);
          end
          default: begin
            if (interval_over(exp_ticks)) begin
              r.breath_done = 1'b1;
              start_stroke(PH_RISE, PH_INSP);
            end
          end
        endcase
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH result %0d: %s", results_seen, what);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
        return;
      end
      want = pending_results.pop_front();
      if (got.step_pulse !== want.step_pulse)
        report_mismatch($sformatf("step_pulse %b, want %b", got.step_pulse, want.step_pulse));
      if (got.direction !== want.direction)
        report_mismatch($sformatf("direction %b, want %b", got.direction, want.direction));
      if (got.drive_enable !== want.drive_enable)
        report_mismatch($sformatf("drive_enable %b, want %b",
                                  got.drive_enable, want.drive_enable));
      if (got.phase !== want.phase)
        report_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
      if (got.breath_done !== want.breath_done)
        report_mismatch($sformatf("breath_done %b, want %b",
                                  got.breath_done, want.breath_done));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals; every input known from time zero
  // --------------------------------------------------------------------------
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       in_tick   = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_step_pulse;
  logic                       out_direction;
  logic                       out_drive_enable;
  logic [1:0]                 out_phase;
  logic                       out_breath_done;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_TRAVEL_STEPS;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

  breath_scoreboard sb;
  bit               hold_req = 1'b0;   // asks the receiver for its long hold-off

  initial begin
    forever #5 clk = ~clk;
  end

  breath_cycle_stepper_sequencer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick          (in_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_step_pulse   (out_step_pulse),
    .out_direction    (out_direction),
    .out_drive_enable (out_drive_enable),
    .out_phase        (out_phase),
    .out_breath_done  (out_breath_done),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitors: sample both handshakes on the rising edge. A result always
  // belongs to an item taken at an earlier edge, so the order of the two
  // calls within one edge does not matter.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n && in_valid && !in_stall) sb.note_tick(in_tick);
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.step_pulse   = out_step_pulse;
      got.direction    = out_direction;
      got.drive_enable = out_drive_enable;
      got.phase        = phase_t'(out_phase);
      got.breath_done  = out_breath_done;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern in segments of random length and density, some
  // with no stalls at all. Once asked, it holds off for a long stretch so
  // the result register fills and the block stalls the sender.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int  seg;
    int  pct;
    bit  held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        repeat (150) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      seg = $urandom_range(8, 60);
      case ($urandom_range(0, 4))
        0, 1:    pct = 0;
        2:       pct = 30;
        3:       pct = 60;
        default: pct = 90;
      endcase
      repeat (seg) begin
        out_stall <= ($urandom_range(0, 99) < pct);
        @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: tick items in bursts with random gaps. Valid stays up across
  // back-to-back items and the payload holds while stalled.
  // --------------------------------------------------------------------------
  task automatic send_ticks(input int count, input int zero_pct, input int max_gap);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = $urandom_range(0, max_gap);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid <= 1'b1;
      in_tick  <= ($urandom_range(0, 99) >= zero_pct);
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // wait until every predicted result has come back
  task automatic settle();
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    sb.set_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_all(input logic [CFG_DATA_WIDTH-1:0] travel,
                             input logic [CFG_DATA_WIDTH-1:0] rise,
                             input logic [CFG_DATA_WIDTH-1:0] insp,
                             input logic [CFG_DATA_WIDTH-1:0] lower,
                             input logic [CFG_DATA_WIDTH-1:0] expir);
    write_reg(REG_TRAVEL_STEPS, travel);
    write_reg(REG_RISE_STEP_TICKS, rise);
    write_reg(REG_INSP_PAUSE_TICKS, insp);
    write_reg(REG_LOWER_STEP_TICKS, lower);
    write_reg(REG_EXP_PAUSE_TICKS, expir);
  endtask

  // mostly short intervals so phases turn over; now and then all ones or noise
  function automatic logic [CFG_DATA_WIDTH-1:0] pick_ticks();
    case ($urandom_range(0, 19))
      0:       return '1;
      1:       return CFG_DATA_WIDTH'($urandom);
      default: return CFG_DATA_WIDTH'($urandom_range(0, 4));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [CFG_DATA_WIDTH-1:0] data;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: a few ticks into the first rise interval
    send_ticks(4, 25, 2);
    settle();

    // all zero: rise limit drops below the running count, so the interval
    // ends on the next tick; zero intervals then step on every tick
    program_all('0, '0, '0, '0, '0);

    // run out the 800 steps left over from reset
    while (sb.ph == PH_RISE) begin
      send_ticks(64, 0, 0);
      settle();
    end

    // zero travel: both step phases are skipped, breath_done every other tick
    send_ticks(6, 0, 1);
    settle();

    // single-step strokes with idle ticks mixed in
    write_reg(REG_TRAVEL_STEPS, CFG_DATA_WIDTH'(1));
    send_ticks(8, 25, 1);
    settle();

    // every register at its maximum
    program_all('1, '1, '1, '1, '1);
    send_ticks(3, 0, 0);
    settle();

    // writes to unused indexes are dropped; then small settings again,
    // lowered below the running count
    write_reg(CFG_INDEX_WIDTH'(REG_EXP_PAUSE_TICKS + $urandom_range(1, 3)), '1);
    program_all(CFG_DATA_WIDTH'(3), CFG_DATA_WIDTH'(1), CFG_DATA_WIDTH'(2),
                '0, CFG_DATA_WIDTH'(1));
    send_ticks(4, 0, 0);

    // random part: reprogram some registers between runs of ticks; the
    // pressure run is long enough to outlast a receiver segment
    for (int p = 0; p < 6; p++) begin
      settle();
      for (int r = REG_TRAVEL_STEPS; r <= REG_EXP_PAUSE_TICKS; r++) begin
        if (p == 0 || $urandom_range(0, 3) != 0) begin
          if (r == REG_TRAVEL_STEPS) begin
            // junk above the travel width; short strokes keep breaths coming
            data = CFG_DATA_WIDTH'($urandom);
            data[STEP_COUNT_WIDTH-1:0] = STEP_COUNT_WIDTH'($urandom_range(0, 5));
          end else begin
            data = pick_ticks();
          end
          write_reg(CFG_INDEX_WIDTH'(r), data);
        end
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_INDEX_WIDTH'(REG_EXP_PAUSE_TICKS + $urandom_range(1, 3)),
                  CFG_DATA_WIDTH'($urandom));
      if (p == 3) hold_req = 1'b1;
      case ($urandom_range(0, 2))
        0:       send_ticks((p == 3) ? 75 : 25, 15, 0);
        1:       send_ticks((p == 3) ? 75 : 25, 15, 2);
        default: send_ticks((p == 3) ? 75 : 25, 15, 6);
      endcase
    end

    // drain, wait out the latency, then the verdict
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
